// ===== rtl/core/mlci_pkg.sv =====
package mlci_pkg;

    // Fixed widths of the beat fields.
    localparam int COORD_BITS = 11;
    localparam int COLOR_BITS = 8;
    localparam int NUM_CHAN   = 3;

    // Item kinds.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COLOR_BITS-1:0] color_t;

    typedef struct packed {
        logic   kind;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        color_t start_red;
        color_t start_green;
        color_t start_blue;
        color_t end_red;
        color_t end_green;
        color_t end_blue;
    } item_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        color_t red;
        color_t green;
        color_t blue;
        logic   last;
    } pixel_t;

    // Line setup after endpoint ordering and case selection.
    typedef struct packed {
        coord_t                      x0;
        coord_t                      y0;
        logic                        steep;
        logic                        minor_inc;
        coord_t                      major;
        coord_t                      minor;
        logic [NUM_CHAN-1:0][COLOR_BITS-1:0] start_color;
        logic [NUM_CHAN-1:0][COLOR_BITS-1:0] diff_mag;
        logic [NUM_CHAN-1:0]         diff_neg;
    } setup_t;

    // Setup sequencer states.
    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV_START,
        ST_DIV_WAIT
    } state_t;

endpackage

// ===== rtl/core/mlci_order.sv =====
module mlci_order (
    input  mlci_pkg::item_t  item,
    output mlci_pkg::setup_t setup
);

    mlci_pkg::coord_t adx;
    mlci_pkg::coord_t ady;
    logic             steep;
    logic             swap;
    mlci_pkg::coord_t x0;
    mlci_pkg::coord_t y0;
    mlci_pkg::coord_t x1;
    mlci_pkg::coord_t y1;
    logic [mlci_pkg::NUM_CHAN-1:0][mlci_pkg::COLOR_BITS-1:0] c_a;
    logic [mlci_pkg::NUM_CHAN-1:0][mlci_pkg::COLOR_BITS-1:0] c_b;
    logic [mlci_pkg::NUM_CHAN-1:0][mlci_pkg::COLOR_BITS-1:0] c0;
    logic [mlci_pkg::NUM_CHAN-1:0][mlci_pkg::COLOR_BITS-1:0] c1;

    // Axis lengths and the shallow or steep choice; equal lengths go steep.
    always_comb
    begin
        adx   = (item.start_x > item.end_x) ? item.start_x - item.end_x
                                            : item.end_x - item.start_x;
        ady   = (item.start_y > item.end_y) ? item.start_y - item.end_y
                                            : item.end_y - item.start_y;
        steep = !(adx > ady);
        swap  = steep ? (item.start_y > item.end_y) : (item.start_x > item.end_x);
    end

    // Order the endpoints along the major axis. Channel 0 is red, 1 green
    // and 2 blue.
    always_comb
    begin
        c_a = {item.start_blue, item.start_green, item.start_red};
        c_b = {item.end_blue, item.end_green, item.end_red};
        if (swap)
        begin
            x0 = item.end_x;
            y0 = item.end_y;
            x1 = item.start_x;
            y1 = item.start_y;
            c0 = c_b;
            c1 = c_a;
        end
        else
        begin
            x0 = item.start_x;
            y0 = item.start_y;
            x1 = item.end_x;
            y1 = item.end_y;
            c0 = c_a;
            c1 = c_b;
        end
    end

    // Assemble the setup record, including the color differences.
    always_comb
    begin
        setup.x0          = x0;
        setup.y0          = y0;
        setup.steep       = steep;
        setup.minor_inc   = steep ? (x1 >= x0) : (y1 >= y0);
        setup.major       = steep ? ady : adx;
        setup.minor       = steep ? adx : ady;
        setup.start_color = c0;
        for (int k = 0; k < mlci_pkg::NUM_CHAN; k++)
        begin
            setup.diff_neg[k] = c1[k] < c0[k];
            setup.diff_mag[k] = setup.diff_neg[k] ? c0[k] - c1[k] : c1[k] - c0[k];
        end
    end

endmodule

// ===== rtl/core/mlci_div.sv =====
module mlci_div #(
    parameter int QW = 16,
    parameter int DW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [QW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [QW-1:0] quotient
);

    localparam int CW = $clog2(QW + 1);

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [QW-1:0] quo_reg;
    logic [QW-1:0] quo_next;
    logic [DW-1:0] dvs_reg;
    logic [DW-1:0] dvs_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    // One restoring step per cycle: the dividend shifts out the top of the
    // quotient register while quotient bits shift in at the bottom.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[QW-1]};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(QW);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/midpoint_line_color_interp_unit.sv =====
// Midpoint line drawer with per-pixel RGB interpolation. A beat of kind load
// takes two endpoints and one color per endpoint and gives no pixel; each
// beat of kind tick then gives the next pixel of the line with its color
// rounded to nearest and a last mark on the final pixel, and a tick while no
// line is loaded gives nothing. Ticks are taken one per cycle while item_stall
// is low. After a load the block holds item_stall high while one shared
// serial divider works out the red, green and blue steps in turn at one
// quotient bit per cycle. A load while a line is being drawn replaces that
// line.
module midpoint_line_color_interp_unit #(
    parameter int COLOR_FRAC_BITS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  mlci_pkg::item_t  item,
    output logic             pixel_valid,
    input  logic             pixel_stall,
    output mlci_pkg::pixel_t pixel
);

    localparam int CB  = mlci_pkg::COORD_BITS;
    localparam int NC  = mlci_pkg::NUM_CHAN;
    localparam int F   = COLOR_FRAC_BITS;
    localparam int QW  = F + mlci_pkg::COLOR_BITS;
    localparam int DB  = CB + 3;
    localparam logic [QW:0] HALF = (QW + 1)'(1) << (F - 1);

    mlci_pkg::setup_t setup;
    mlci_pkg::state_t state_reg;
    mlci_pkg::state_t state_next;

    logic              item_accept;
    logic              load_fire;
    logic              tick_fire;
    logic              div_start;
    logic              div_done;
    logic [QW-1:0]     div_dividend;
    logic [QW-1:0]     div_quotient;
    logic              chan_last;

    logic              active_reg;
    logic              active_next;
    logic [1:0]        chan_reg;
    logic [1:0]        chan_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    mlci_pkg::pixel_t  out_reg;
    mlci_pkg::pixel_t  out_next;

    logic              steep_reg;
    logic              minor_inc_reg;
    logic [CB-1:0]     col_reg;
    logic [CB-1:0]     col_next;
    logic [CB-1:0]     row_reg;
    logic [CB-1:0]     row_next;
    logic [CB-1:0]     steps_reg;
    logic [CB-1:0]     major_reg;
    logic [CB-1:0]     minor_reg;
    logic signed [DB-1:0] dec_reg;
    logic signed [DB-1:0] dec_next;
    logic signed [DB-1:0] dec_init;
    logic [DB-1:0]     minor2;
    logic [DB-1:0]     major2;
    logic              minor_move;
    logic [NC-1:0][QW-1:0]   acc_reg;
    logic [NC-1:0][QW-1:0]   acc_next;
    logic [NC-1:0][QW:0]     step_reg;
    logic [NC-1:0][mlci_pkg::COLOR_BITS-1:0] mag_reg;
    logic [NC-1:0]           neg_reg;
    logic [QW:0]             quo_signed;
    logic [NC-1:0][QW:0]     rnd;

    mlci_order u_order (
        .item  (item),
        .setup (setup)
    );

    mlci_div #(
        .QW (QW),
        .DW (CB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (major_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Handshake on the item side: busy during setup or with a pixel held.
    assign item_stall  = (state_reg != mlci_pkg::ST_RUN) || (out_valid_reg && pixel_stall);
    assign item_accept = item_valid && !item_stall;
    assign load_fire   = item_accept && (item.kind == mlci_pkg::KIND_LOAD);
    assign tick_fire   = item_accept && (item.kind == mlci_pkg::KIND_TICK) && active_reg;

    assign div_dividend = {mag_reg[chan_reg], F'(0)};
    assign chan_last    = (chan_reg == 2'(NC - 1));
    assign quo_signed   = (major_reg == '0) ? '0 :
                          neg_reg[chan_reg] ? -{1'b0, div_quotient} : {1'b0, div_quotient};

    // Setup sequencer: one divider run per color channel.
    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        div_start  = 1'b0;
        case (state_reg)
            mlci_pkg::ST_RUN:
            begin
                if (load_fire)
                begin
                    state_next = mlci_pkg::ST_DIV_START;
                    chan_next  = '0;
                end
            end
            mlci_pkg::ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = mlci_pkg::ST_DIV_WAIT;
            end
            mlci_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (chan_last)
                    begin
                        state_next = mlci_pkg::ST_RUN;
                    end
                    else
                    begin
                        chan_next  = chan_reg + 1'b1;
                        state_next = mlci_pkg::ST_DIV_START;
                    end
                end
            end
            default:
            begin
                state_next = mlci_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlci_pkg::ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Midpoint step and color accumulation for the next pixel.
    always_comb
    begin
        minor2     = {2'b00, minor_reg, 1'b0};
        major2     = {2'b00, major_reg, 1'b0};
        dec_init   = $signed({2'b00, setup.minor, 1'b0}) - $signed({3'b000, setup.major});
        minor_move = dec_reg > 0;
        dec_next   = dec_reg + $signed(minor2) - (minor_move ? $signed(major2) : '0);
        col_next   = col_reg;
        row_next   = row_reg;
        if (steep_reg)
        begin
            row_next = row_reg + 1'b1;
            if (minor_move)
            begin
                col_next = minor_inc_reg ? col_reg + 1'b1 : col_reg - 1'b1;
            end
        end
        else
        begin
            col_next = col_reg + 1'b1;
            if (minor_move)
            begin
                row_next = minor_inc_reg ? row_reg + 1'b1 : row_reg - 1'b1;
            end
        end
        for (int k = 0; k < NC; k++)
        begin
            acc_next[k] = acc_reg[k] + step_reg[k][QW-1:0];
            rnd[k]      = {1'b0, acc_reg[k]} + HALF;
        end
    end

    // Pixel beat built from the current position and color.
    always_comb
    begin
        out_next.pixel_x = col_reg;
        out_next.pixel_y = row_reg;
        out_next.red     = rnd[0][F+7:F];
        out_next.green   = rnd[1][F+7:F];
        out_next.blue    = rnd[2][F+7:F];
        out_next.last    = (steps_reg == '0);
    end

    always_comb
    begin
        active_next = active_reg;
        if (load_fire)
        begin
            active_next = 1'b1;
        end
        else if (tick_fire && (steps_reg == '0))
        begin
            active_next = 1'b0;
        end
        out_valid_next = out_valid_reg && pixel_stall;
        if (tick_fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            chan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Line registers: loaded by a load beat, advanced by each tick but the last of a line.
    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            steep_reg     <= setup.steep;
            minor_inc_reg <= setup.minor_inc;
            col_reg       <= setup.x0;
            row_reg       <= setup.y0;
            steps_reg     <= setup.major;
            major_reg     <= setup.major;
            minor_reg     <= setup.minor;
            dec_reg       <= dec_init;
            mag_reg       <= setup.diff_mag;
            neg_reg       <= setup.diff_neg;
            for (int k = 0; k < NC; k++)
            begin
                acc_reg[k] <= {setup.start_color[k], F'(0)};
            end
        end
        else if (tick_fire && (steps_reg != '0))
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            dec_reg   <= dec_next;
            steps_reg <= steps_reg - 1'b1;
            acc_reg   <= acc_next;
        end
        if ((state_reg == mlci_pkg::ST_DIV_WAIT) && div_done)
        begin
            step_reg[chan_reg] <= quo_signed;
        end
        if (tick_fire)
        begin
            out_reg <= out_next;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;

`ifndef NO_ASSERTIONS
    // A load always starts a setup, so the next cycle is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && (item.kind == mlci_pkg::KIND_LOAD)) |=> item_stall)
        else $error("load not followed by setup");

    // A new pixel only follows an accepted tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pixel_valid) |->
            $past(item_valid && !item_stall && (item.kind == mlci_pkg::KIND_TICK)))
        else $error("pixel without tick");

    // The final pixel of a line ends the drawing.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(pixel_valid) && pixel.last) |-> !active_reg)
        else $error("line still active after last pixel");

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == mlci_pkg::ST_DIV_WAIT))
        else $error("divider done outside setup wait");
`endif

endmodule

// ===== bench/midpoint_line_color_interp_unit_tb.sv =====
module midpoint_line_color_interp_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS     = 8;
    localparam int ROUND_HALF    = 1 << (FRAC_BITS - 1);
    localparam int COORD_MAX     = (1 << mlci_pkg::COORD_BITS) - 1;
    localparam int PHASE_ITEMS   = 190;
    localparam int HOLD_CYCLES   = 250;
    localparam int SETTLE_CYCLES = 80;
    localparam int QUIET_LIMIT   = 3000;

    // Tracks the line being drawn and queues the pixel each tick must produce.
    class pixel_scoreboard;
        bit               drawing;
        bit               y_major;
        bit               minor_up;
        mlci_pkg::coord_t col;
        mlci_pkg::coord_t row;
        int               pixels_after;
        int               midpoint;
        int               major_len;
        int               minor_len;
        int               shade[mlci_pkg::NUM_CHAN];
        int               shade_step[mlci_pkg::NUM_CHAN];
        mlci_pkg::pixel_t expected_q[$];
        int               errors;

        // Fold one accepted input beat into the line state.
        function void note_item(mlci_pkg::item_t it);
            int               x0, y0, x1, y1, adx, ady, mag, quo, tmp;
            int               c0[mlci_pkg::NUM_CHAN];
            int               c1[mlci_pkg::NUM_CHAN];
            bit               swap, diag_move;
            mlci_pkg::pixel_t px;
            if (it.kind == mlci_pkg::KIND_LOAD)
            begin
                x0 = int'(it.start_x);
                y0 = int'(it.start_y);
                x1 = int'(it.end_x);
                y1 = int'(it.end_y);
                c0 = '{int'(it.start_red), int'(it.start_green), int'(it.start_blue)};
                c1 = '{int'(it.end_red), int'(it.end_green), int'(it.end_blue)};
                adx = (x0 > x1) ? x0 - x1 : x1 - x0;
                ady = (y0 > y1) ? y0 - y1 : y1 - y0;
                // A slope of one and vertical lines take the steep case.
                y_major = !(adx > ady);
                swap = y_major ? (y0 > y1) : (x0 > x1);
                if (swap)
                begin
                    tmp = x0; x0 = x1; x1 = tmp;
                    tmp = y0; y0 = y1; y1 = tmp;
                    for (int k = 0; k < mlci_pkg::NUM_CHAN; k++)
                    begin
                        tmp = c0[k]; c0[k] = c1[k]; c1[k] = tmp;
                    end
                end
                major_len    = y_major ? ady : adx;
                minor_len    = y_major ? adx : ady;
                minor_up     = y_major ? (x1 >= x0) : (y1 >= y0);
                col          = mlci_pkg::coord_t'(x0);
                row          = mlci_pkg::coord_t'(y0);
                pixels_after = major_len;
                midpoint     = 2 * minor_len - major_len;
                // Per-pixel color step, truncated toward zero; a one-point line
                // keeps its start color.
                for (int k = 0; k < mlci_pkg::NUM_CHAN; k++)
                begin
                    mag = ((c0[k] > c1[k]) ? c0[k] - c1[k] : c1[k] - c0[k]) << FRAC_BITS;
                    quo = (major_len == 0) ? 0 : mag / major_len;
                    shade_step[k] = (c1[k] >= c0[k]) ? quo : -quo;
                    shade[k]      = c0[k] << FRAC_BITS;
                end
                drawing = 1'b1;
            end
            else if (drawing)
            begin
                px.pixel_x = col;
                px.pixel_y = row;
                px.red     = mlci_pkg::color_t'((shade[0] + ROUND_HALF) >> FRAC_BITS);
                px.green   = mlci_pkg::color_t'((shade[1] + ROUND_HALF) >> FRAC_BITS);
                px.blue    = mlci_pkg::color_t'((shade[2] + ROUND_HALF) >> FRAC_BITS);
                px.last    = (pixels_after == 0);
                expected_q = {expected_q, px};
                if (pixels_after == 0)
                    drawing = 1'b0;
                else
                begin
                    // Midpoint step, mirrored for a decreasing minor axis.
                    diag_move = midpoint > 0;
                    midpoint += diag_move ? 2 * minor_len - 2 * major_len : 2 * minor_len;
                    if (y_major)
                    begin
                        row = row + 1'b1;
                        if (diag_move)
                            col = minor_up ? col + 1'b1 : col - 1'b1;
                    end
                    else
                    begin
                        col = col + 1'b1;
                        if (diag_move)
                            row = minor_up ? row + 1'b1 : row - 1'b1;
                    end
                    for (int k = 0; k < mlci_pkg::NUM_CHAN; k++)
                        shade[k] += shade_step[k];
                    pixels_after--;
                end
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        // Compare an accepted pixel beat with the oldest expectation.
        function void check_pixel(mlci_pkg::pixel_t got);
            mlci_pkg::pixel_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: pixel expected none, got (%0d,%0d) rgb %0d %0d %0d last %0d",
                         $time, got.pixel_x, got.pixel_y, got.red, got.green, got.blue,
                         got.last);
                return;
            end
            want = expected_q.pop_front();
            compare_field("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x));
            compare_field("pixel_y", 32'(want.pixel_y), 32'(got.pixel_y));
            compare_field("red", 32'(want.red), 32'(got.red));
            compare_field("green", 32'(want.green), 32'(got.green));
            compare_field("blue", 32'(want.blue), 32'(got.blue));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    mlci_pkg::item_t  item = '0;
    logic             pixel_valid;
    logic             pixel_stall = 1'b0;
    mlci_pkg::pixel_t pixel;

    int     send_idle_pct = 22;
    int     recv_idle_pct = 67;
    bit     hold_request = 1'b0;

    pixel_scoreboard sb = new();

    midpoint_line_color_interp_unit #(
        .COLOR_FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel(pixel)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Random line load; the far end lies within span of the start on each axis.
    function automatic mlci_pkg::item_t make_line(int span);
        mlci_pkg::item_t it;
        int              x0, y0, x1, y1;
        x0 = $urandom_range(COORD_MAX);
        y0 = $urandom_range(COORD_MAX);
        x1 = x0 + int'($urandom_range(2 * span)) - span;
        y1 = y0 + int'($urandom_range(2 * span)) - span;
        x1 = (x1 < 0) ? 0 : (x1 > COORD_MAX) ? COORD_MAX : x1;
        y1 = (y1 < 0) ? 0 : (y1 > COORD_MAX) ? COORD_MAX : y1;
        it.kind        = mlci_pkg::KIND_LOAD;
        it.start_x     = mlci_pkg::coord_t'(x0);
        it.start_y     = mlci_pkg::coord_t'(y0);
        it.end_x       = mlci_pkg::coord_t'(x1);
        it.end_y       = mlci_pkg::coord_t'(y1);
        it.start_red   = mlci_pkg::color_t'($urandom);
        it.start_green = mlci_pkg::color_t'($urandom);
        it.start_blue  = mlci_pkg::color_t'($urandom);
        it.end_red     = mlci_pkg::color_t'($urandom);
        it.end_green   = mlci_pkg::color_t'($urandom);
        it.end_blue    = mlci_pkg::color_t'($urandom);
        return it;
    endfunction

    // Ticks carry random junk in the endpoint fields, which the block ignores.
    function automatic mlci_pkg::item_t tick_beat();
        mlci_pkg::item_t it;
        it      = make_line(COORD_MAX);
        it.kind = mlci_pkg::KIND_TICK;
        return it;
    endfunction

    function automatic mlci_pkg::item_t line_beat(int x0, int y0, int x1, int y1,
                                                  logic [23:0] c0, logic [23:0] c1);
        mlci_pkg::item_t it;
        it.kind        = mlci_pkg::KIND_LOAD;
        it.start_x     = mlci_pkg::coord_t'(x0);
        it.start_y     = mlci_pkg::coord_t'(y0);
        it.end_x       = mlci_pkg::coord_t'(x1);
        it.end_y       = mlci_pkg::coord_t'(y1);
        it.start_red   = c0[23:16];
        it.start_green = c0[15:8];
        it.start_blue  = c0[7:0];
        it.end_red     = c1[23:16];
        it.end_green   = c1[15:8];
        it.end_blue    = c1[7:0];
        return it;
    endfunction

    function automatic int major_of(mlci_pkg::item_t it);
        int adx, ady;
        adx = (it.start_x > it.end_x) ? int'(it.start_x - it.end_x)
                                      : int'(it.end_x - it.start_x);
        ady = (it.start_y > it.end_y) ? int'(it.start_y - it.end_y)
                                      : int'(it.end_y - it.start_y);
        return (adx > ady) ? adx : ady;
    endfunction

    // Offer one input beat after a random gap and hold it until accepted.
    task automatic send_beat(mlci_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // Load a line and send a number of ticks; ticks past the last pixel find
    // the block idle and are not counted.
    task automatic draw_line(mlci_pkg::item_t ld, int ticks, inout int counted);
        int major;
        major = major_of(ld);
        send_beat(ld);
        counted++;
        for (int i = 0; i < ticks; i++)
        begin
            send_beat(tick_beat());
            if (i <= major)
                counted++;
        end
    endtask

    // Stop offering beats until every expected pixel has arrived.
    task automatic drain_pixels();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_q.size() != 0);
    endtask

    // Mostly whole lines, short ones by far the most common, with lines cut off
    // by the next load and back-to-back loads mixed in.
    task automatic run_random(int quota);
        int              counted, sel, span, major, ticks;
        mlci_pkg::item_t ld;
        counted = 0;
        while (counted < quota)
        begin
            sel   = $urandom_range(99);
            span  = $urandom_range(99);
            span  = (span < 70) ? 12 : (span < 95) ? 64 : COORD_MAX;
            ld    = make_line(span);
            major = major_of(ld);
            if (sel < 10)
                ticks = 0;
            else if (sel < 22 || major > 300)
                ticks = $urandom_range(1, (major < 40) ? major + 1 : 40);
            else
                ticks = major + 1 + (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0);
            draw_line(ld, ticks, counted);
        end
    endtask

    // Sink side: random stalls, or one long hold-off when requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                pixel_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                pixel_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Both channels are sampled at the same edge, inputs first.
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            sb.note_item(item);
        if (rst_n && pixel_valid && !pixel_stall)
            sb.check_pixel(pixel);
    end

    // End the run when neither channel has moved a beat for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((item_valid && !item_stall) || (pixel_valid && !pixel_stall)))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int              beats;
        int              len;
        mlci_pkg::item_t ld;
        beats = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a tick before any line, a one-point line followed by an
        // idle tick, slopes of plus and minus one, vertical and horizontal
        // lines at the coordinate extremes, and a full-span line that the
        // next load replaces part way.
        send_beat(tick_beat());
        draw_line(line_beat(0, COORD_MAX, 0, COORD_MAX, 24'hFF0080, 24'h00FF01), 2, beats);
        draw_line(line_beat(3, 3, 0, 0, 24'hFFFFFF, 24'h000000), 4, beats);
        draw_line(line_beat(COORD_MAX, 0, COORD_MAX - 3, 3, 24'h00FF7F, 24'hFF0080), 4, beats);
        draw_line(line_beat(1000, COORD_MAX, 1000, COORD_MAX - 2, 24'h123456, 24'hEDCBA9),
                  3, beats);
        draw_line(line_beat(COORD_MAX, 10, COORD_MAX - 3, 10, 24'h000000, 24'hFFFFFF), 4, beats);
        draw_line(line_beat(0, 0, COORD_MAX, 1, 24'h00FF00, 24'hFF00FF), 2, beats);
        drain_pixels();

        // The sink holds off for a long stretch while a line keeps ticking
        // in, so the block backs up and stalls its input.
        len          = $urandom_range(20, 60);
        ld           = make_line(12);
        ld.start_x   = mlci_pkg::coord_t'($urandom_range(1000));
        ld.start_y   = mlci_pkg::coord_t'($urandom_range(1000));
        ld.end_x     = ld.start_x + mlci_pkg::coord_t'(len);
        ld.end_y     = ld.start_y + mlci_pkg::coord_t'($urandom_range(len));
        hold_request = 1'b1;
        draw_line(ld, major_of(ld) + 1, beats);

        run_random(PHASE_ITEMS);
        drain_pixels();

        send_idle_pct = 67;
        recv_idle_pct = 22;
        run_random(PHASE_ITEMS);
        drain_pixels();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS);
        drain_pixels();

        // Let any stray pixel show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
